// ===== rtl/izn_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Izhikevich neuron update engine.
`default_nettype none

package izn_pkg;

   // Neuron store geometry; the index fields are as wide as the store address
   localparam int NEURON_COUNT = 1024;
   localparam int IDX_W        = $clog2(NEURON_COUNT);

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // Field widths
   localparam int DATA_W = 32;
   localparam int RES_W  = 17;
   localparam int MUL_W  = 35;
   localparam int PROD_W = 2 * MUL_W;
   localparam int WIDE_W = 72;

   // Model constants, Q0.16 and Q16.16
   localparam logic [RES_W-1:0]       RES_ONE  = 17'd65536;
   localparam logic signed [MUL_W-1:0] K_B      = 35'sd13107;
   localparam logic signed [MUL_W-1:0] K_A_RS   = 35'sd1311;
   localparam logic signed [MUL_W-1:0] K_A_FS   = 35'sd6554;
   localparam logic signed [MUL_W-1:0] K_QUAD   = 35'sd2621;
   localparam logic signed [MUL_W-1:0] EFF_ONE  = 35'sd65536;
   localparam logic signed [31:0]      K_C      = -32'sd4259840;
   localparam logic signed [31:0]      K_D_RS   = 32'sd524288;
   localparam logic signed [31:0]      K_D_FS   = 32'sd131072;
   localparam logic signed [31:0]      K_CONST  = 32'sd9175040;
   localparam logic signed [31:0]      K_THRESH = 32'sd1966080;

   // Noise generator constants
   localparam logic [63:0] NOISE_GOLD = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] NOISE_MIX1 = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] NOISE_MIX2 = 64'h94D049BB133111EB;

   // Request codes
   typedef enum logic [1:0] {
      REQ_LOAD      = 2'd0,
      REQ_INTEGRATE = 2'd1,
      REQ_DELIVER   = 2'd2
   } req_code_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NOISE_SEED    = 3'd0,
      CSR_STEP_DT       = 3'd1,
      CSR_NOISE_GAIN    = 3'd2,
      CSR_EXC_DECAY     = 3'd3,
      CSR_INH_DECAY     = 3'd4,
      CSR_RECOVERY_RATE = 3'd5,
      CSR_RELEASE_KEEP  = 3'd6,
      CSR_DEPRESSION_ON = 3'd7
   } csr_index_type;

   // Sequencer steps
   typedef enum logic [5:0] {
      ST_CLEAR, ST_IDLE,
      ST_LOAD_MUL, ST_LOAD_WR,
      ST_SEED_LO, ST_SEED_HI, ST_SEED_MIX, ST_IDX_LO, ST_IDX_HI,
      ST_M1_LL, ST_M1_HL, ST_M1_LH, ST_M1_END,
      ST_M2_LL, ST_M2_HL, ST_M2_LH, ST_M2_END,
      ST_GAIN, ST_CUR, ST_EXC, ST_INH, ST_RES,
      ST_VSQ, ST_VV, ST_QLO, ST_QHI, ST_QSUM, ST_DERIV, ST_DT_MUL, ST_VNEW,
      ST_BV, ST_DIFF, ST_AMUL, ST_TVAL, ST_UMUL, ST_FINISH,
      ST_DL_SRC, ST_DL_TGT, ST_DL_MUL, ST_DL_ADD, ST_DL_DEP, ST_DL_RES
   } izn_state_type;

   // Zero-extend an unsigned word into a multiplier operand
   function automatic logic signed [MUL_W-1:0] zx_op(input logic [31:0] x);
      return signed'({3'b000, x});
   endfunction

   // Round to nearest, ties up, then drop n fraction bits
   function automatic logic signed [PROD_W-1:0] rnd_sh(input logic signed [PROD_W-1:0] p,
                                                      input int unsigned n);
      logic signed [PROD_W-1:0] half;
      half = PROD_W'(1) <<< (n - 1);
      return (p + half) >>> n;
   endfunction

   // Clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] x);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(32'sh7FFFFFFF);
      lo = WIDE_W'(-33'sd2147483648);
      if (x > hi) return 32'sh7FFFFFFF;
      if (x < lo) return 32'sh80000000;
      return x[31:0];
   endfunction

   // Clamp a resource value to zero..one
   function automatic logic [RES_W-1:0] clamp_res(input logic signed [WIDE_W-1:0] x);
      if (x < 0) return '0;
      if (x > WIDE_W'(RES_ONE)) return RES_ONE;
      return x[RES_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/izn_if.sv =====
// Valid/ready channel interfaces for neuron requests and neuron results.
`default_nettype none

interface izn_req_if
   import izn_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              req_type;
   logic [IDX_W-1:0]        neuron;
   logic                    is_inhibitory;
   logic signed [DATA_W-1:0] init_v;
   logic signed [DATA_W-1:0] ext_current;
   logic                    first_of_tick;
   logic [IDX_W-1:0]        target;
   logic signed [DATA_W-1:0] weight;
   logic                    last_synapse;

   modport source (output valid, req_type, neuron, is_inhibitory, init_v, ext_current,
                   first_of_tick, target, weight, last_synapse, input ready);
   modport sink   (input valid, req_type, neuron, is_inhibitory, init_v, ext_current,
                   first_of_tick, target, weight, last_synapse, output ready);
endinterface

interface izn_rsp_if
   import izn_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [IDX_W-1:0]        neuron_out;
   logic                    fired;
   logic                    inhibitory_out;
   logic signed [DATA_W-1:0] membrane;

   modport source (output valid, neuron_out, fired, inhibitory_out, membrane, input ready);
   modport sink   (input valid, neuron_out, fired, inhibitory_out, membrane, output ready);
endinterface

`default_nettype wire

// ===== rtl/izhikevich_neuron_update.sv =====
// Izhikevich neuron update engine: per-neuron state store and shared-multiplier sequencer.
// Load, deliver and integrate each run as a sequence of steps; deliver adds depression steps
// after the last synapse of an excitatory source when depression is on. One item is in work at a time.
// All steps share the single 35x35 multiplier, one product per sequencer step.
// A finished result waits in the output register while the next item is taken.
// After reset a clearing pass over all 1024 neurons writes currents and resources before
// the first request transfer; configuration writes are taken throughout.
`default_nettype none

module izhikevich_neuron_update
   import izn_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   izn_req_if.sink              req_chan,
   izn_rsp_if.source            rsp_chan,
   input  wire                  csr_we,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic [63:0]       cfg_seed_ff;
   logic [20:0]       cfg_dt_ff;
   logic [26:0]       cfg_gain_ff;
   logic [RES_W-1:0]  cfg_exc_dec_ff;
   logic [RES_W-1:0]  cfg_inh_dec_ff;
   logic [RES_W-1:0]  cfg_rate_ff;
   logic [RES_W-1:0]  cfg_keep_ff;
   logic              cfg_dep_ff;

   // Sequencer control
   izn_state_type     state_ff, state_in;
   logic [IDX_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [31:0]       tick_ff, tick_in;
   logic              half_ff, half_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Item and working registers
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [IDX_W-1:0]         tgt_ff, tgt_in;
   logic                     fs_ff, fs_in;
   logic                     last_ff, last_in;
   logic signed [31:0]       ext_ff, ext_in;
   logic signed [31:0]       w_ff, w_in;
   logic signed [31:0]       v_ff, v_in;
   logic signed [31:0]       u_ff, u_in;
   logic signed [31:0]       exc_ff, exc_in;
   logic signed [31:0]       inh_ff, inh_in;
   logic [RES_W-1:0]         res_ff, res_in;
   logic signed [31:0]       cur_ff, cur_in;
   logic signed [31:0]       f_ff, f_in;
   logic [63:0]              z_ff, z_in;
   logic [63:0]              acc_ff, acc_in;
   logic [47:0]              vv_ff, vv_in;
   logic signed [MUL_W-1:0]  diff_ff, diff_in;
   logic signed [MUL_W-1:0]  t_ff, t_in;
   logic signed [PROD_W-1:0] prod_ff;

   // Result register
   logic [IDX_W-1:0]   rsp_neuron_ff, rsp_neuron_in;
   logic               rsp_fired_ff, rsp_fired_in;
   logic               rsp_inh_ff, rsp_inh_in;
   logic signed [31:0] rsp_mem_ff, rsp_mem_in;

   // Neuron store
   logic signed [31:0] pot_mem [NEURON_COUNT];
   logic signed [31:0] rec_mem [NEURON_COUNT];
   logic signed [31:0] exc_mem [NEURON_COUNT];
   logic signed [31:0] inh_mem [NEURON_COUNT];
   logic [RES_W-1:0]   res_mem [NEURON_COUNT];
   logic               kind_mem [NEURON_COUNT];

   logic signed [31:0] pot_rd_ff, rec_rd_ff, exc_rd_ff, inh_rd_ff;
   logic [RES_W-1:0]   res_rd_ff;
   logic               kind_rd_ff;

   logic [IDX_W-1:0]   rd_addr, wr_addr;
   logic               pot_we, rec_we, exc_we, inh_we, res_we, kind_we;
   logic signed [31:0] pot_wdata, rec_wdata, exc_wdata, inh_wdata;
   logic [RES_W-1:0]   res_wdata;
   logic               kind_wdata;

   // Shared multiplier
   logic signed [MUL_W-1:0] mul_a, mul_b;

   // Datapath helpers
   logic                     req_xfer, rsp_xfer, fin_go;
   logic signed [PROD_W-1:0] prod_r16, prod_r17, prod_r24;
   logic [63:0]              sum64, mix64;
   logic signed [WIDE_W-1:0] five_v, q_round;
   logic signed [31:0]       u_upd, v_fin, u_fin;
   logic                     fire;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_xfer = rsp_valid_ff && rsp_chan.ready;
   assign fin_go   = !rsp_valid_ff || rsp_chan.ready;

   assign prod_r16 = rnd_sh(prod_ff, 16);
   assign prod_r17 = rnd_sh(prod_ff, 17);
   assign prod_r24 = rnd_sh(prod_ff, 24);
   assign sum64    = acc_ff + {prod_ff[31:0], 32'd0};
   assign mix64    = z_ff + sum64;
   assign five_v   = (WIDE_W'(v_ff) <<< 2) + WIDE_W'(v_ff);
   assign q_round  = signed'(WIDE_W'((acc_ff + 64'd32768) >> 16));

   // Finish step: recovery update and threshold reset
   assign u_upd = sat32(WIDE_W'(u_ff) + WIDE_W'(prod_r16));
   assign fire  = v_ff >= K_THRESH;
   assign v_fin = fire ? K_C : v_ff;
   assign u_fin = fire ? sat32(WIDE_W'(u_upd) + WIDE_W'(fs_ff ? K_D_FS : K_D_RS)) : u_upd;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_seed_ff    <= '0;
         cfg_dt_ff      <= 21'd65536;
         cfg_gain_ff    <= '0;
         cfg_exc_dec_ff <= '0;
         cfg_inh_dec_ff <= '0;
         cfg_rate_ff    <= '0;
         cfg_keep_ff    <= RES_ONE;
         cfg_dep_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NOISE_SEED:    cfg_seed_ff    <= csr_wdata;
            CSR_STEP_DT:       cfg_dt_ff      <= csr_wdata[20:0];
            CSR_NOISE_GAIN:    cfg_gain_ff    <= csr_wdata[26:0];
            CSR_EXC_DECAY:     cfg_exc_dec_ff <= csr_wdata[RES_W-1:0];
            CSR_INH_DECAY:     cfg_inh_dec_ff <= csr_wdata[RES_W-1:0];
            CSR_RECOVERY_RATE: cfg_rate_ff    <= csr_wdata[RES_W-1:0];
            CSR_RELEASE_KEEP:  cfg_keep_ff    <= csr_wdata[RES_W-1:0];
            CSR_DEPRESSION_ON: cfg_dep_ff     <= csr_wdata[0];
            default:           cfg_dep_ff     <= cfg_dep_ff;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:    if (clr_cnt_ff == IDX_W'(NEURON_COUNT - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_chan.valid) begin
               case (req_chan.req_type)
                  REQ_LOAD:      state_in = ST_LOAD_MUL;
                  REQ_INTEGRATE: state_in = ST_SEED_LO;
                  REQ_DELIVER:   state_in = ST_DL_SRC;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD_MUL: state_in = ST_LOAD_WR;
         ST_LOAD_WR:  state_in = ST_IDLE;
         ST_SEED_LO:  state_in = ST_SEED_HI;
         ST_SEED_HI:  state_in = ST_SEED_MIX;
         ST_SEED_MIX: state_in = ST_IDX_LO;
         ST_IDX_LO:   state_in = ST_IDX_HI;
         ST_IDX_HI:   state_in = ST_M1_LL;
         ST_M1_LL:    state_in = ST_M1_HL;
         ST_M1_HL:    state_in = ST_M1_LH;
         ST_M1_LH:    state_in = ST_M1_END;
         ST_M1_END:   state_in = ST_M2_LL;
         ST_M2_LL:    state_in = ST_M2_HL;
         ST_M2_HL:    state_in = ST_M2_LH;
         ST_M2_LH:    state_in = ST_M2_END;
         ST_M2_END:   state_in = ST_GAIN;
         ST_GAIN:     state_in = ST_CUR;
         ST_CUR:      state_in = ST_EXC;
         ST_EXC:      state_in = ST_INH;
         ST_INH:      state_in = ST_RES;
         ST_RES:      state_in = ST_VSQ;
         ST_VSQ:      state_in = ST_VV;
         ST_VV:       state_in = ST_QLO;
         ST_QLO:      state_in = ST_QHI;
         ST_QHI:      state_in = ST_QSUM;
         ST_QSUM:     state_in = ST_DERIV;
         ST_DERIV:    state_in = ST_DT_MUL;
         ST_DT_MUL:   state_in = ST_VNEW;
         ST_VNEW:     state_in = half_ff ? ST_BV : ST_VSQ;
         ST_BV:       state_in = ST_DIFF;
         ST_DIFF:     state_in = ST_AMUL;
         ST_AMUL:     state_in = ST_TVAL;
         ST_TVAL:     state_in = ST_UMUL;
         ST_UMUL:     state_in = ST_FINISH;
         ST_FINISH:   if (fin_go) state_in = ST_IDLE;
         ST_DL_SRC:   state_in = ST_DL_TGT;
         ST_DL_TGT:   state_in = ST_DL_MUL;
         ST_DL_MUL:   state_in = ST_DL_ADD;
         ST_DL_ADD:   state_in = (last_ff && cfg_dep_ff && !fs_ff) ? ST_DL_DEP : ST_IDLE;
         ST_DL_DEP:   state_in = ST_DL_RES;
         ST_DL_RES:   state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Store ports and multiplier operands
   always_comb begin
      rd_addr    = idx_ff;
      wr_addr    = idx_ff;
      pot_we     = 1'b0;
      rec_we     = 1'b0;
      exc_we     = 1'b0;
      inh_we     = 1'b0;
      res_we     = 1'b0;
      kind_we    = 1'b0;
      pot_wdata  = v_fin;
      rec_wdata  = u_fin;
      exc_wdata  = exc_ff;
      inh_wdata  = inh_ff;
      res_wdata  = res_ff;
      kind_wdata = fs_ff;
      mul_a      = '0;
      mul_b      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_addr   = clr_cnt_ff;
            exc_we    = 1'b1;
            inh_we    = 1'b1;
            res_we    = 1'b1;
            exc_wdata = '0;
            inh_wdata = '0;
            res_wdata = RES_ONE;
         end
         ST_LOAD_MUL: begin
            mul_a = K_B;
            mul_b = MUL_W'(v_ff);
         end
         ST_LOAD_WR: begin
            pot_we    = 1'b1;
            rec_we    = 1'b1;
            kind_we   = 1'b1;
            pot_wdata = v_ff;
            rec_wdata = sat32(WIDE_W'(prod_r16));
         end
         ST_SEED_LO: begin
            mul_a = zx_op(tick_ff);
            mul_b = zx_op(NOISE_GOLD[31:0]);
         end
         ST_SEED_HI: begin
            mul_a = zx_op(tick_ff);
            mul_b = zx_op(NOISE_GOLD[63:32]);
         end
         ST_SEED_MIX: begin
            mul_a = zx_op(32'(idx_ff));
            mul_b = zx_op(NOISE_MIX1[31:0]);
         end
         ST_IDX_LO: begin
            mul_a = zx_op(32'(idx_ff));
            mul_b = zx_op(NOISE_MIX1[63:32]);
         end
         ST_M1_LL: begin
            mul_a = zx_op(z_ff[31:0]);
            mul_b = zx_op(NOISE_MIX1[31:0]);
         end
         ST_M1_HL: begin
            mul_a = zx_op(z_ff[63:32]);
            mul_b = zx_op(NOISE_MIX1[31:0]);
         end
         ST_M1_LH: begin
            mul_a = zx_op(z_ff[31:0]);
            mul_b = zx_op(NOISE_MIX1[63:32]);
         end
         ST_M2_LL: begin
            mul_a = zx_op(z_ff[31:0]);
            mul_b = zx_op(NOISE_MIX2[31:0]);
         end
         ST_M2_HL: begin
            mul_a = zx_op(z_ff[63:32]);
            mul_b = zx_op(NOISE_MIX2[31:0]);
         end
         ST_M2_LH: begin
            mul_a = zx_op(z_ff[31:0]);
            mul_b = zx_op(NOISE_MIX2[63:32]);
         end
         ST_GAIN: begin
            mul_a = zx_op(32'(cfg_gain_ff));
            mul_b = zx_op(32'(z_ff[63:40]));
         end
         ST_CUR: begin
            mul_a = MUL_W'(exc_ff);
            mul_b = zx_op(32'(cfg_exc_dec_ff));
         end
         ST_EXC: begin
            mul_a = MUL_W'(inh_ff);
            mul_b = zx_op(32'(cfg_inh_dec_ff));
         end
         ST_INH: begin
            mul_a = zx_op(32'(RES_ONE - res_ff));
            mul_b = zx_op(32'(cfg_rate_ff));
         end
         ST_VSQ: begin
            mul_a = MUL_W'(v_ff);
            mul_b = MUL_W'(v_ff);
         end
         ST_QLO: begin
            mul_a = zx_op(vv_ff[31:0]);
            mul_b = K_QUAD;
         end
         ST_QHI: begin
            mul_a = zx_op(32'(vv_ff[47:32]));
            mul_b = K_QUAD;
         end
         ST_DT_MUL: begin
            mul_a = zx_op(32'(cfg_dt_ff));
            mul_b = MUL_W'(f_ff);
         end
         ST_BV: begin
            mul_a = K_B;
            mul_b = MUL_W'(v_ff);
         end
         ST_AMUL: begin
            mul_a = diff_ff;
            mul_b = fs_ff ? K_A_FS : K_A_RS;
         end
         ST_UMUL: begin
            mul_a = zx_op(32'(cfg_dt_ff));
            mul_b = t_ff;
         end
         ST_FINISH: begin
            // hold the product while the result register is full
            mul_a = zx_op(32'(cfg_dt_ff));
            mul_b = t_ff;
            pot_we = fin_go;
            rec_we = fin_go;
            exc_we = fin_go;
            inh_we = fin_go;
            res_we = fin_go;
         end
         ST_DL_TGT: rd_addr = tgt_ff;
         ST_DL_MUL: begin
            mul_a = MUL_W'(w_ff);
            mul_b = fs_ff ? EFF_ONE : zx_op(32'(res_ff));
         end
         ST_DL_ADD: begin
            wr_addr   = tgt_ff;
            exc_we    = !fs_ff;
            inh_we    = fs_ff;
            exc_wdata = sat32(WIDE_W'(exc_ff) + WIDE_W'(prod_r16));
            inh_wdata = sat32(WIDE_W'(inh_ff) + WIDE_W'(prod_r16));
         end
         ST_DL_DEP: begin
            mul_a = zx_op(32'(res_ff));
            mul_b = zx_op(32'(cfg_keep_ff));
         end
         ST_DL_RES: begin
            res_we    = 1'b1;
            res_wdata = clamp_res(WIDE_W'(prod_r16));
         end
         default: begin
            rd_addr = idx_ff;
         end
      endcase
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   // Datapath next values
   always_comb begin
      clr_cnt_in    = clr_cnt_ff;
      tick_in       = tick_ff;
      half_in       = half_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_xfer;
      idx_in        = idx_ff;
      tgt_in        = tgt_ff;
      fs_in         = fs_ff;
      last_in       = last_ff;
      ext_in        = ext_ff;
      w_in          = w_ff;
      v_in          = v_ff;
      u_in          = u_ff;
      exc_in        = exc_ff;
      inh_in        = inh_ff;
      res_in        = res_ff;
      cur_in        = cur_ff;
      f_in          = f_ff;
      z_in          = z_ff;
      acc_in        = acc_ff;
      vv_in         = vv_ff;
      diff_in       = diff_ff;
      t_in          = t_ff;
      rsp_neuron_in = rsp_neuron_ff;
      rsp_fired_in  = rsp_fired_ff;
      rsp_inh_in    = rsp_inh_ff;
      rsp_mem_in    = rsp_mem_ff;
      unique case (state_ff)
         ST_CLEAR: clr_cnt_in = clr_cnt_ff + 1'b1;
         ST_IDLE: begin
            // latch the transferred request
            if (req_xfer) begin
               idx_in  = req_chan.neuron;
               tgt_in  = req_chan.target;
               fs_in   = req_chan.is_inhibitory;
               v_in    = req_chan.init_v;
               ext_in  = req_chan.ext_current;
               w_in    = req_chan.weight;
               last_in = req_chan.last_synapse;
               half_in = 1'b0;
               if (req_chan.req_type == REQ_INTEGRATE && req_chan.first_of_tick) begin
                  tick_in = tick_ff + 1'b1;
               end
            end
         end
         ST_SEED_HI: begin
            v_in   = pot_rd_ff;
            u_in   = rec_rd_ff;
            exc_in = exc_rd_ff;
            inh_in = inh_rd_ff;
            res_in = res_rd_ff;
            fs_in  = kind_rd_ff;
            acc_in = prod_ff[63:0];
         end
         ST_SEED_MIX: z_in   = cfg_seed_ff ^ sum64;
         ST_IDX_LO:   acc_in = prod_ff[63:0];
         ST_IDX_HI:   z_in   = mix64 ^ (mix64 >> 30);
         ST_M1_HL:    acc_in = prod_ff[63:0];
         ST_M1_LH:    acc_in = sum64;
         ST_M1_END:   z_in   = sum64 ^ (sum64 >> 27);
         ST_M2_HL:    acc_in = prod_ff[63:0];
         ST_M2_LH:    acc_in = sum64;
         ST_M2_END:   z_in   = sum64 ^ (sum64 >> 31);
         ST_CUR: begin
            cur_in = sat32(WIDE_W'(exc_ff) + WIDE_W'(inh_ff) + WIDE_W'(ext_ff)
                           + WIDE_W'(prod_r24));
         end
         ST_EXC: exc_in = sat32(WIDE_W'(prod_r16));
         ST_INH: inh_in = sat32(WIDE_W'(prod_r16));
         ST_RES: begin
            if (cfg_dep_ff) begin
               res_in = clamp_res(signed'(WIDE_W'(res_ff)) + WIDE_W'(prod_r16));
            end
         end
         ST_VV:   vv_in  = prod_r16[47:0];
         ST_QHI:  acc_in = prod_ff[63:0];
         ST_QSUM: acc_in = sum64;
         ST_DERIV: begin
            f_in = sat32(q_round + five_v + WIDE_W'(K_CONST) - WIDE_W'(u_ff)
                         + WIDE_W'(cur_ff));
         end
         ST_VNEW: begin
            v_in    = sat32(WIDE_W'(v_ff) + WIDE_W'(prod_r17));
            half_in = 1'b1;
         end
         ST_DIFF: diff_in = MUL_W'(prod_r16) - MUL_W'(u_ff);
         ST_TVAL: t_in    = MUL_W'(prod_r16);
         ST_FINISH: begin
            // present the result once the output register is free
            if (fin_go) begin
               rsp_valid_in  = 1'b1;
               rsp_neuron_in = idx_ff;
               rsp_fired_in  = fire;
               rsp_inh_in    = fs_ff;
               rsp_mem_in    = v_fin;
            end
         end
         ST_DL_TGT: begin
            fs_in  = kind_rd_ff;
            res_in = res_rd_ff;
         end
         ST_DL_MUL: begin
            exc_in = exc_rd_ff;
            inh_in = inh_rd_ff;
         end
         default: begin
            half_in = half_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         tick_ff      <= '0;
         half_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         tick_ff      <= tick_in;
         half_ff      <= half_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers and shared multiplier
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      tgt_ff        <= tgt_in;
      fs_ff         <= fs_in;
      last_ff       <= last_in;
      ext_ff        <= ext_in;
      w_ff          <= w_in;
      v_ff          <= v_in;
      u_ff          <= u_in;
      exc_ff        <= exc_in;
      inh_ff        <= inh_in;
      res_ff        <= res_in;
      cur_ff        <= cur_in;
      f_ff          <= f_in;
      z_ff          <= z_in;
      acc_ff        <= acc_in;
      vv_ff         <= vv_in;
      diff_ff       <= diff_in;
      t_ff          <= t_in;
      prod_ff       <= mul_a * mul_b;
      rsp_neuron_ff <= rsp_neuron_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_inh_ff    <= rsp_inh_in;
      rsp_mem_ff    <= rsp_mem_in;
   end

   // Neuron store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (pot_we)  pot_mem[wr_addr]  <= pot_wdata;
      if (rec_we)  rec_mem[wr_addr]  <= rec_wdata;
      if (exc_we)  exc_mem[wr_addr]  <= exc_wdata;
      if (inh_we)  inh_mem[wr_addr]  <= inh_wdata;
      if (res_we)  res_mem[wr_addr]  <= res_wdata;
      if (kind_we) kind_mem[wr_addr] <= kind_wdata;
      pot_rd_ff  <= pot_mem[rd_addr];
      rec_rd_ff  <= rec_mem[rd_addr];
      exc_rd_ff  <= exc_mem[rd_addr];
      inh_rd_ff  <= inh_mem[rd_addr];
      res_rd_ff  <= res_mem[rd_addr];
      kind_rd_ff <= kind_mem[rd_addr];
   end

   // Result channel
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.neuron_out     = rsp_neuron_ff;
   assign rsp_chan.fired          = rsp_fired_ff;
   assign rsp_chan.inhibitory_out = rsp_inh_ff;
   assign rsp_chan.membrane       = rsp_mem_ff;

   // No request transfer while the store is being cleared
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_chan.ready)
      else $error("request taken during clearing pass");

   // A spiking neuron reports the reset potential
   a_fired_reset: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.fired) |-> (rsp_chan.membrane == K_C))
      else $error("fired result without reset potential");

   // A silent neuron stays below threshold
   a_silent_below: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.fired) |-> (rsp_chan.membrane < K_THRESH))
      else $error("silent result at or above threshold");

   // A new result only comes from the finish step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("result raised outside finish step");

endmodule

`default_nettype wire

// ===== tb/tb_chan_if.sv =====
// Testbench-side note: channel interfaces come from rtl/izn_if.sv; this file holds shared stimulus types.
package tb_izn_pkg;
   import izn_pkg::*;

   // One request as the testbench builds it
   typedef struct {
      req_code_type      kind;
      logic [9:0]        neuron;
      logic              is_inh;
      logic signed [31:0] init_v;
      logic signed [31:0] ext_cur;
      logic              first;
      logic [9:0]        target;
      logic signed [31:0] weight;
      logic              last;
   } neuron_req_t;

   // One expected result
   typedef struct {
      logic [9:0]        neuron;
      logic              fired;
      logic              inh;
      logic signed [31:0] membrane;
   } neuron_rsp_t;
endpackage

// ===== tb/tb_top.sv =====
// Top-level testbench: drives neuron requests, predicts results and checks them.
module tb_top;
   import izn_pkg::*;
   import tb_izn_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock, reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   izn_req_if req_chan ();
   izn_rsp_if rsp_chan ();

   izhikevich_neuron_update dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata));

   // Predictor state
   longint        st_v[1024];
   longint        st_u[1024];
   longint        st_exc[1024];
   longint        st_inh[1024];
   longint        st_res[1024];
   bit            st_kind[1024];
   bit            st_loaded[1024];
   bit [31:0]     tick_cnt;
   bit [63:0]     cf_seed;
   longint        cf_dt, cf_gain, cf_edec, cf_idec, cf_rrate, cf_keep, cf_dep;

   neuron_rsp_t   expected_q[$];
   int            errors;
   int            rsp_seen;
   int            items_sent;
   longint        cycles;
   bit            no_idle;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Abort on a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic longint rnd_q(longint p, int n);
      return (p + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint sat_w(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint clamp_one(longint x);
      if (x < 0) return 0;
      if (x > 65536) return 65536;
      return x;
   endfunction

   function automatic longint membrane_half(longint v, longint u, longint cur);
      longint vv, f;
      vv = rnd_q(v * v, 16);
      f = rnd_q(vv * 2621, 16) + 5 * v + 9175040 - u + cur;
      return sat_w(v + rnd_q(cf_dt * sat_w(f), 17));
   endfunction

   // Register write, mirrored into the predictor
   task automatic write_csr(csr_index_type idx, logic [63:0] val);
      @(negedge clock);
      csr_we = 1; csr_index = idx; csr_wdata = val;
      @(negedge clock);
      csr_we = 0;
      case (idx)
         CSR_NOISE_SEED:    cf_seed = val;
         CSR_STEP_DT:       cf_dt = val[20:0];
         CSR_NOISE_GAIN:    cf_gain = val[26:0];
         CSR_EXC_DECAY:     cf_edec = val[16:0];
         CSR_INH_DECAY:     cf_idec = val[16:0];
         CSR_RECOVERY_RATE: cf_rrate = val[16:0];
         CSR_RELEASE_KEEP:  cf_keep = val[16:0];
         CSR_DEPRESSION_ON: cf_dep = val[0];
      endcase
   endtask

   // Work out the effect of one accepted request
   task automatic predict_update(neuron_req_t r);
      int i, tg;
      bit [63:0] z;
      longint jit, cur, v, u, t;
      neuron_rsp_t e;
      i = r.neuron;
      case (r.kind)
         REQ_LOAD: begin
            st_kind[i] = r.is_inh;
            st_v[i] = r.init_v;
            st_u[i] = sat_w(rnd_q(13107 * longint'(r.init_v), 16));
            st_loaded[i] = 1;
         end
         REQ_INTEGRATE: begin
            if (r.first) tick_cnt++;
            z = cf_seed ^ (64'(tick_cnt) * NOISE_GOLD);
            z = z + 64'(i) * NOISE_MIX1;
            z = (z ^ (z >> 30)) * NOISE_MIX1;
            z = (z ^ (z >> 27)) * NOISE_MIX2;
            z ^= z >> 31;
            jit = rnd_q(cf_gain * longint'(z >> 40), 24);
            cur = sat_w(st_exc[i] + st_inh[i] + longint'(r.ext_cur) + jit);
            st_exc[i] = sat_w(rnd_q(st_exc[i] * cf_edec, 16));
            st_inh[i] = sat_w(rnd_q(st_inh[i] * cf_idec, 16));
            if (cf_dep != 0)
               st_res[i] = clamp_one(st_res[i] + rnd_q((65536 - st_res[i]) * cf_rrate, 16));
            v = st_v[i]; u = st_u[i];
            v = membrane_half(v, u, cur);
            v = membrane_half(v, u, cur);
            t = rnd_q((rnd_q(13107 * v, 16) - u) * (st_kind[i] ? 6554 : 1311), 16);
            u = sat_w(u + rnd_q(cf_dt * t, 16));
            e.fired = 0;
            if (v >= 1966080) begin
               v = -4259840;
               u = sat_w(u + (st_kind[i] ? 131072 : 524288));
               e.fired = 1;
            end
            st_v[i] = v; st_u[i] = u;
            e.neuron = i; e.inh = st_kind[i]; e.membrane = v[31:0];
            expected_q.push_back(e);
         end
         REQ_DELIVER: begin
            tg = r.target;
            t = rnd_q(longint'(r.weight) * (st_kind[i] ? 65536 : st_res[i]), 16);
            if (st_kind[i]) st_inh[tg] = sat_w(st_inh[tg] + t);
            else st_exc[tg] = sat_w(st_exc[tg] + t);
            if (r.last && cf_dep != 0 && !st_kind[i])
               st_res[i] = clamp_one(rnd_q(st_res[i] * cf_keep, 16));
         end
         default: ;
      endcase
   endtask

   // Send one request; hold until the transfer
   task automatic send_req(neuron_req_t r);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 30) @(negedge clock);
      req_chan.valid = 1;
      req_chan.req_type = r.kind;
      req_chan.neuron = r.neuron;
      req_chan.is_inhibitory = r.is_inh;
      req_chan.init_v = r.init_v;
      req_chan.ext_current = r.ext_cur;
      req_chan.first_of_tick = r.first;
      req_chan.target = r.target;
      req_chan.weight = r.weight;
      req_chan.last_synapse = r.last;
      do @(posedge clock); while (!req_chan.ready);
      predict_update(r);
      items_sent++;
      @(negedge clock);
      req_chan.valid = 0;
   endtask

   function automatic neuron_req_t rand_req();
      neuron_req_t r;
      int pick;
      r.neuron = $urandom_range(1023);
      r.target = $urandom_range(1023);
      r.is_inh = $urandom_range(1);
      r.init_v = $urandom;
      r.ext_cur = $urandom;
      r.first = $urandom_range(1);
      r.weight = $urandom;
      r.last = $urandom_range(1);
      pick = $urandom_range(99);
      // mostly physiological ranges so neurons evolve and fire
      if (pick < 85) begin
         r.init_v = -(65 << 16) + $signed($urandom_range(40 << 16));
         r.ext_cur = $signed($urandom_range(30 << 16)) - (5 << 16);
         r.weight = $signed($urandom_range(20 << 16)) - (10 << 16);
      end
      pick = $urandom_range(99);
      r.kind = pick < 15 ? REQ_LOAD : (pick < 60 ? REQ_INTEGRATE : REQ_DELIVER);
      // keep accesses on loaded neurons
      if (r.kind != REQ_LOAD && !st_loaded[r.neuron]) r.kind = REQ_LOAD;
      return r;
   endfunction

   task automatic wait_drain();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // Response side: random stalls, compare against the oldest prediction
   initial begin
      neuron_rsp_t e;
      rsp_chan.ready = 0;
      forever begin
         @(negedge clock);
         rsp_chan.ready = no_idle || ($urandom_range(99) >= 30);
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_seen++;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result neuron=%0d", $time, rsp_chan.neuron_out);
               errors++;
            end else begin
               e = expected_q.pop_front();
               if (rsp_chan.neuron_out !== e.neuron || rsp_chan.fired !== e.fired ||
                   rsp_chan.inhibitory_out !== e.inh || rsp_chan.membrane !== e.membrane) begin
                  $display("%0t: mismatch exp n=%0d f=%0d k=%0d v=%0d got n=%0d f=%0d k=%0d v=%0d",
                     $time, e.neuron, e.fired, e.inh, e.membrane, rsp_chan.neuron_out,
                     rsp_chan.fired, rsp_chan.inhibitory_out, rsp_chan.membrane);
                  errors++;
               end
            end
         end
      end
   end

   task automatic test_directed();
      neuron_req_t r;
      r = '{REQ_LOAD, 10'd0, 1'b0, -32'sd4259840, 0, 0, 0, 0, 0};
      send_req(r);
      r.neuron = 1023; r.is_inh = 1; r.init_v = 32'sh7FFFFFFF; send_req(r);
      r.neuron = 5; r.is_inh = 0; r.init_v = 32'sh80000000; send_req(r);
      r.neuron = 7; r.is_inh = 1; r.init_v = 32'sd1966080; send_req(r);
      r.kind = REQ_DELIVER; r.neuron = 0; r.target = 1023; r.weight = 32'sh7FFFFFFF;
      r.last = 1; send_req(r);
      r.neuron = 7; r.target = 0; r.weight = 32'sh80000000; r.last = 0; send_req(r);
      r.neuron = 1023; r.target = 5; r.weight = 32'sh7FFFFFFF; r.last = 1; send_req(r);
      r.kind = REQ_INTEGRATE; r.first = 1;
      foreach (r.init_v[k]) ;
      r.neuron = 0; r.ext_cur = 32'sh7FFFFFFF; send_req(r);
      r.first = 0; r.neuron = 1023; r.ext_cur = 32'sh80000000; send_req(r);
      r.neuron = 5; r.ext_cur = 0; send_req(r);
      r.neuron = 7; r.ext_cur = 20 << 16; send_req(r);
      // unknown request code changes nothing
      r.kind = req_code_type'(2'd3); r.neuron = 5; send_req(r);
      r.kind = REQ_INTEGRATE; r.first = 1; send_req(r);
      wait_drain();
   endtask

   task automatic test_random(int count);
      for (int n = 0; n < count; n++) begin
         no_idle = (n >= count / 2 && n < count / 2 + 80);
         send_req(rand_req());
      end
      no_idle = 0;
      wait_drain();
   endtask

   task automatic test_config_phase(int phase);
      case (phase)
         0: begin
            write_csr(CSR_NOISE_SEED, 64'hFFFFFFFFFFFFFFFF);
            write_csr(CSR_STEP_DT, 21'h100000);
            write_csr(CSR_NOISE_GAIN, 27'h4000000);
            write_csr(CSR_EXC_DECAY, 17'h10000);
            write_csr(CSR_INH_DECAY, 17'h10000);
            write_csr(CSR_RECOVERY_RATE, 17'h10000);
            write_csr(CSR_RELEASE_KEEP, 0);
            write_csr(CSR_DEPRESSION_ON, 1);
         end
         1: begin
            write_csr(CSR_NOISE_SEED, {$urandom, $urandom});
            write_csr(CSR_STEP_DT, 32768);
            write_csr(CSR_NOISE_GAIN, $urandom_range(5 << 16));
            write_csr(CSR_EXC_DECAY, 58000);
            write_csr(CSR_INH_DECAY, 50000);
            write_csr(CSR_RECOVERY_RATE, 3000);
            write_csr(CSR_RELEASE_KEEP, 40000);
            write_csr(CSR_DEPRESSION_ON, 1);
         end
         default: begin
            write_csr(CSR_NOISE_SEED, 0);
            write_csr(CSR_STEP_DT, 0);
            write_csr(CSR_NOISE_GAIN, 0);
            write_csr(CSR_EXC_DECAY, 0);
            write_csr(CSR_INH_DECAY, 0);
            write_csr(CSR_RECOVERY_RATE, 0);
            write_csr(CSR_RELEASE_KEEP, 65536);
            write_csr(CSR_DEPRESSION_ON, 0);
         end
      endcase
   endtask

   initial begin
      cycles = 0; errors = 0; rsp_seen = 0; items_sent = 0; no_idle = 0;
      reset = 1; csr_we = 0; csr_index = '0; csr_wdata = '0;
      req_chan.valid = 0; req_chan.req_type = '0; req_chan.neuron = '0;
      req_chan.is_inhibitory = 0; req_chan.init_v = '0; req_chan.ext_current = '0;
      req_chan.first_of_tick = 0; req_chan.target = '0; req_chan.weight = '0;
      req_chan.last_synapse = 0;
      for (int k = 0; k < 1024; k++) begin
         st_v[k] = 0; st_u[k] = 0; st_exc[k] = 0; st_inh[k] = 0;
         st_res[k] = 65536; st_kind[k] = 0; st_loaded[k] = 0;
      end
      tick_cnt = 0; cf_seed = 0; cf_dt = 65536; cf_gain = 0; cf_edec = 0;
      cf_idec = 0; cf_rrate = 0; cf_keep = 65536; cf_dep = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      test_directed();
      test_random(450);
      test_config_phase(0);
      test_random(450);
      test_config_phase(1);
      test_random(500);
      test_config_phase(2);
      test_random(450);

      $display("Covered %0d requests and %0d checked results over four register settings.",
         items_sent, rsp_seen);
      if (errors == 0 && expected_q.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
